FILE: design/ordered_array_edit_engine_defines.svh
// Assertion macros shared by the checker of the ordered array edit engine.
`ifndef ORDERED_ARRAY_EDIT_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_EDIT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OAEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define OAEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/oaee_pkg.sv
// Types and constants of the ordered array edit engine.
package oaee_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_DUMP   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_APPEND = 3'd3,
        CMD_SEARCH = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BADPOS   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_EMPTY    = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         position;
        logic signed [DATA_W-1:0] data_value;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] result_value;
        logic [IDX_W-1:0]         result_index;
        logic [CNT_W-1:0]         element_count;
        logic                     last;
    } out_t;

endpackage

FILE: design/oaee_mem.sv
// Element store: one write port and one read port with registered read data.
module oaee_mem #(
    parameter int DEPTH = oaee_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [oaee_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [oaee_pkg::DATA_W-1:0] rd_data
);

    logic [oaee_pkg::DATA_W-1:0] mem_array [DEPTH];
    logic [oaee_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/oaee_ctrl.sv
// Command sequencer: checks, scan loop over the element store, result register.
module oaee_ctrl #(
    parameter int DEPTH = oaee_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  oaee_pkg::in_t               request,
    output logic                        result_strobe,
    output oaee_pkg::out_t              result,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [oaee_pkg::DATA_W-1:0] mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [oaee_pkg::DATA_W-1:0] mem_rdata
);

    localparam int CNT_W = oaee_pkg::CNT_W;
    localparam int IDX_W = oaee_pkg::IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    oaee_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic                  strobe_reg, strobe_next;

    logic [oaee_pkg::CMD_W-1:0]  op_reg, op_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic [oaee_pkg::DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]            ptr_reg, ptr_next;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic [AW-1:0]               paddr_reg, paddr_next;
    logic                        found_reg, found_next;
    logic [AW-1:0]               where_reg, where_next;
    logic [oaee_pkg::DATA_W-1:0] removed_reg, removed_next;
    oaee_pkg::out_t              out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= oaee_pkg::ST_IDLE;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        ptr_reg     <= ptr_next;
        rem_reg     <= rem_next;
        paddr_reg   <= paddr_next;
        found_reg   <= found_next;
        where_reg   <= where_next;
        removed_reg <= removed_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        strobe_next  = 1'b0;
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        paddr_next   = paddr_reg;
        found_next   = found_reg;
        where_next   = where_reg;
        removed_next = removed_reg;
        out_next     = out_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = val_reg;
        mem_re       = 1'b0;
        mem_raddr    = ptr_reg[AW-1:0];

        case (state_reg)
            oaee_pkg::ST_IDLE:
            begin
                pend_next = 1'b0;
                if (start)
                begin
                    op_next    = request.cmd;
                    pos_next   = request.position;
                    val_next   = request.data_value;
                    found_next = 1'b0;
                    where_next = '0;
                    out_next.status        = oaee_pkg::STAT_OK;
                    out_next.result_value  = '0;
                    out_next.result_index  = '0;
                    out_next.element_count = cnt_reg;
                    out_next.last          = 1'b1;
                    case (request.cmd)
                        oaee_pkg::CMD_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                out_next.status = oaee_pkg::STAT_EMPTY;
                                strobe_next     = 1'b1;
                            end
                            else
                            begin
                                rem_next   = cnt_reg;
                                ptr_next   = '0;
                                state_next = oaee_pkg::ST_SCAN;
                            end
                        end
                        oaee_pkg::CMD_INSERT:
                        begin
                            if ({1'b0, request.position} > cnt_reg)
                            begin
                                out_next.status = oaee_pkg::STAT_BADPOS;
                                strobe_next     = 1'b1;
                            end
                            else if (cnt_reg >= DEPTH_CNT)
                            begin
                                out_next.status = oaee_pkg::STAT_FULL;
                                strobe_next     = 1'b1;
                            end
                            else
                            begin
                                // Shift runs from the top element down to the position.
                                rem_next   = cnt_reg - {1'b0, request.position};
                                ptr_next   = cnt_reg - CNT_W'(1);
                                state_next = oaee_pkg::ST_SCAN;
                            end
                        end
                        oaee_pkg::CMD_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                out_next.status = oaee_pkg::STAT_EMPTY;
                                strobe_next     = 1'b1;
                            end
                            else if ({1'b0, request.position} >= cnt_reg)
                            begin
                                out_next.status = oaee_pkg::STAT_BADPOS;
                                strobe_next     = 1'b1;
                            end
                            else
                            begin
                                rem_next   = cnt_reg - {1'b0, request.position};
                                ptr_next   = {1'b0, request.position};
                                state_next = oaee_pkg::ST_SCAN;
                            end
                        end
                        oaee_pkg::CMD_APPEND:
                        begin
                            if (cnt_reg >= DEPTH_CNT)
                            begin
                                out_next.status = oaee_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_reg[AW-1:0];
                                mem_wdata = request.data_value;
                                cnt_next  = cnt_reg + CNT_W'(1);
                                out_next.element_count = cnt_reg + CNT_W'(1);
                            end
                            strobe_next = 1'b1;
                        end
                        oaee_pkg::CMD_SEARCH:
                        begin
                            rem_next   = cnt_reg;
                            ptr_next   = '0;
                            state_next = oaee_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end

            oaee_pkg::ST_SCAN:
            begin
                // Consume the word read in the previous cycle.
                if (pend_reg)
                begin
                    case (op_reg)
                        oaee_pkg::CMD_DUMP:
                        begin
                            out_next.status        = oaee_pkg::STAT_OK;
                            out_next.result_value  = mem_rdata;
                            out_next.result_index  = IDX_W'(paddr_reg);
                            out_next.element_count = cnt_reg;
                            out_next.last          = (rem_reg == '0);
                            strobe_next            = 1'b1;
                        end
                        oaee_pkg::CMD_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = paddr_reg + AW'(1);
                            mem_wdata = mem_rdata;
                        end
                        oaee_pkg::CMD_DELETE:
                        begin
                            if (paddr_reg == pos_reg[AW-1:0])
                            begin
                                removed_next = mem_rdata;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = paddr_reg - AW'(1);
                                mem_wdata = mem_rdata;
                            end
                        end
                        default:
                        begin
                            if (mem_rdata == val_reg)
                            begin
                                found_next = 1'b1;
                                where_next = paddr_reg;
                            end
                        end
                    endcase
                end

                if (rem_reg != '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg[AW-1:0];
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg[AW-1:0];
                    rem_next   = rem_reg - CNT_W'(1);
                    if (op_reg == oaee_pkg::CMD_INSERT)
                    begin
                        ptr_next = ptr_reg - CNT_W'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (rem_reg == '0 && !pend_reg)
                begin
                    state_next             = oaee_pkg::ST_IDLE;
                    out_next.status        = oaee_pkg::STAT_OK;
                    out_next.result_value  = '0;
                    out_next.result_index  = '0;
                    out_next.element_count = cnt_reg;
                    out_next.last          = 1'b1;
                    case (op_reg)
                        oaee_pkg::CMD_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg[AW-1:0];
                            mem_wdata = val_reg;
                            cnt_next  = cnt_reg + CNT_W'(1);
                            out_next.element_count = cnt_reg + CNT_W'(1);
                            strobe_next = 1'b1;
                        end
                        oaee_pkg::CMD_DELETE:
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                            out_next.element_count = cnt_reg - CNT_W'(1);
                            out_next.result_value  = removed_reg;
                            strobe_next = 1'b1;
                        end
                        oaee_pkg::CMD_SEARCH:
                        begin
                            if (!found_reg)
                            begin
                                out_next.status = oaee_pkg::STAT_NOTFOUND;
                            end
                            out_next.result_index = IDX_W'(where_reg);
                            strobe_next = 1'b1;
                        end
                        default:
                        begin
                            // Dump results have all gone out during the scan.
                            out_next = out_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = oaee_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != oaee_pkg::ST_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = out_reg;

endmodule

FILE: design/ordered_array_edit_engine.sv
// Ordered array edit engine: top level joining the sequencer and the element store.
//
// A request (cmd, position, data_value) is taken at a rising edge with start high
// and busy low. Every request yields one or more results; each result is shown on
// result for exactly one cycle with result_strobe high, and the final result of a
// request has last set. The receiver cannot hold results off.
//
// Timing, with n the element count before the request:
//   append, rejected requests and unused codes: busy stays low, the result
//   appears in the cycle after the request.
//   dump: busy while the list is scanned; its n results come in an unbroken
//   run, one per cycle, once the first word has been read.
//   insert at p: scans the n - p entries from the top down to p; delete at p:
//   the n - p entries from p up; search: all n entries. Busy rises even when
//   nothing is scanned. Their single result appears in the cycle busy falls.
// The scan is paced by the single read port of the element store: it reads one
// entry per cycle, and shifts write each word back in the cycle after its read.
//
// Reset clears the count and the sequencer; the store itself is not cleared,
// since no entry at or above the count is ever read.
module ordered_array_edit_engine #(
    parameter int DEPTH = oaee_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  oaee_pkg::in_t  request,
    output logic           result_strobe,
    output oaee_pkg::out_t result
);

    localparam int AW = $clog2(DEPTH);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [oaee_pkg::DATA_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [oaee_pkg::DATA_W-1:0] mem_rdata;

    oaee_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_strobe (result_strobe),
        .result        (result),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    oaee_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

FILE: design/oaee_checker.sv
// Port-level checker of the ordered array edit engine and its bind statement.
`include "ordered_array_edit_engine_defines.svh"

module oaee_checker #(
    parameter int DEPTH = oaee_pkg::DEPTH_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input oaee_pkg::in_t  request,
    input logic           result_strobe,
    input oaee_pkg::out_t result
);

    localparam int CNT_W = oaee_pkg::CNT_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic accepted;
    logic error_result;
    logic more_results;
    logic count_ok;

    assign accepted     = start && !busy;
    assign error_result = result_strobe && (result.status != oaee_pkg::STAT_OK);
    assign more_results = result_strobe && !result.last;
    assign count_ok     = (result.element_count <= DEPTH_CNT);

    // An accepted request either starts a scan or answers in the next cycle.
    `OAEE_ASSERT_NEXT(a_accept_progress, accepted, busy || result_strobe, "request left idle")

    // Any status other than ok ends its request at once.
    `OAEE_ASSERT_NOW(a_error_is_last, error_result, result.last, "error result without last")

    // Dump results come in an unbroken run up to the last one.
    `OAEE_ASSERT_NEXT(a_dump_unbroken, more_results, result_strobe, "gap inside a run of results")

    // The count never passes the capacity.
    `OAEE_ASSERT_NOW(a_count_bound, result_strobe, count_ok, "element count above capacity")

endmodule

bind ordered_array_edit_engine oaee_checker #(
    .DEPTH (DEPTH)
) u_oaee_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe),
    .result        (result)
);

FILE: dv/tb_ordered_array_edit_engine.sv
// Testbench for the ordered array edit engine: random and directed list edits against a shadow list.
module tb_ordered_array_edit_engine;
    import oaee_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 25;
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    // Shadow copy of the list; predicts the results of every accepted request.
    class list_tracker;
        logic signed [DATA_W-1:0] elements [LIST_DEPTH];
        int unsigned count;
        out_t pending_results [$];
        int unsigned mismatches;

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        function void push_result(status_t st, logic signed [DATA_W-1:0] val,
                                  int unsigned idx, bit fin);
            out_t r;
            r.status = st;
            r.result_value = val;
            r.result_index = idx[IDX_W-1:0];
            r.element_count = count[CNT_W-1:0];
            r.last = fin;
            pending_results.push_back(r);
        endfunction

        function void note_request(in_t req);
            int unsigned pos;
            int unsigned where;
            bit found;
            logic signed [DATA_W-1:0] removed;
            pos = 32'(req.position);
            case (req.cmd)
                CMD_DUMP:
                    if (count == 0)
                        push_result(STAT_EMPTY, '0, 0, 1'b1);
                    else
                        for (int i = 0; i < count; i++)
                            push_result(STAT_OK, elements[i], i, i == count - 1);
                CMD_INSERT:
                    // The position check comes before the full check.
                    if (pos > count)
                        push_result(STAT_BADPOS, '0, 0, 1'b1);
                    else if (count >= LIST_DEPTH)
                        push_result(STAT_FULL, '0, 0, 1'b1);
                    else
                    begin
                        for (int i = count; i > pos; i--)
                            elements[i] = elements[i-1];
                        elements[pos] = req.data_value;
                        count++;
                        push_result(STAT_OK, '0, 0, 1'b1);
                    end
                CMD_DELETE:
                    if (count == 0)
                        push_result(STAT_EMPTY, '0, 0, 1'b1);
                    else if (pos >= count)
                        push_result(STAT_BADPOS, '0, 0, 1'b1);
                    else
                    begin
                        removed = elements[pos];
                        for (int i = pos; i + 1 < count; i++)
                            elements[i] = elements[i+1];
                        count--;
                        push_result(STAT_OK, removed, 0, 1'b1);
                    end
                CMD_APPEND:
                    if (count >= LIST_DEPTH)
                        push_result(STAT_FULL, '0, 0, 1'b1);
                    else
                    begin
                        elements[count] = req.data_value;
                        count++;
                        push_result(STAT_OK, '0, 0, 1'b1);
                    end
                CMD_SEARCH:
                begin
                    found = 1'b0;
                    where = 0;
                    for (int i = 0; i < count; i++)
                        if (elements[i] == req.data_value)
                        begin
                            found = 1'b1;
                            where = i;
                        end
                    push_result(found ? STAT_OK : STAT_NOTFOUND, '0, where, 1'b1);
                end
                default:
                    push_result(STAT_OK, '0, 0, 1'b1);
            endcase
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual status %0d value %0h",
                         $time, got.status, got.result_value);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
            compare_field("result_value", want.result_value, got.result_value);
            compare_field("result_index", DATA_W'(want.result_index),
                          DATA_W'(got.result_index));
            compare_field("element_count", DATA_W'(want.element_count),
                          DATA_W'(got.element_count));
            compare_field("last", DATA_W'(want.last), DATA_W'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t request = '0;
    logic result_strobe;
    out_t result;
    int unsigned stall_cycles = 0;
    list_tracker board = new();

    ordered_array_edit_engine u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_strobe(result_strobe),
        .result(result)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
                board.check_result(result);
            if ((start && !busy) || result_strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic in_t make_request(logic [CMD_W-1:0] c, int unsigned p,
                                         logic signed [DATA_W-1:0] v);
        in_t req;
        req.cmd = c;
        req.position = p[IDX_W-1:0];
        req.data_value = v;
        return req;
    endfunction

    // Small values make duplicates likely, so searches see several matches.
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return $urandom_range(1) ? WORD_MAX : WORD_MIN;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t random_request();
        in_t req;
        int unsigned pick;
        int unsigned cnt;
        cnt = board.count;
        req = make_request(CMD_DUMP, $urandom, pick_word());
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            req.cmd = CMD_INSERT;
            if ($urandom_range(9) != 0)
                req.position = IDX_W'($urandom_range(cnt));
        end
        else if (pick < 47)
        begin
            req.cmd = CMD_DELETE;
            if (cnt > 0 && $urandom_range(9) != 0)
                req.position = IDX_W'($urandom_range(cnt - 1));
        end
        else if (pick < 67)
            req.cmd = CMD_APPEND;
        else if (pick < 85)
        begin
            req.cmd = CMD_SEARCH;
            if (cnt > 0 && $urandom_range(2) != 0)
                req.data_value = board.elements[$urandom_range(cnt - 1)];
        end
        else if (pick < 95)
            req.cmd = CMD_DUMP;
        else
            req.cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        return req;
    endfunction

    task automatic issue_request(input in_t req, input bit may_idle);
        int unsigned gap;
        if (may_idle && $urandom_range(99) < 24)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(70, 5) : $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= req;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        board.note_request(req);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Commands on an empty list.
        issue_request(make_request(CMD_DUMP, 0, 0), 1'b1);
        issue_request(make_request(CMD_DELETE, 0, 0), 1'b1);
        issue_request(make_request(CMD_SEARCH, 0, 5), 1'b1);
        issue_request(make_request(CMD_INSERT, 5, 1), 1'b1);
        // Build a short list with extremes and a duplicate.
        issue_request(make_request(CMD_INSERT, 0, WORD_MAX), 1'b1);
        issue_request(make_request(CMD_APPEND, 63, WORD_MIN), 1'b1);
        issue_request(make_request(CMD_INSERT, 2, -1), 1'b1);
        issue_request(make_request(CMD_INSERT, 1, 0), 1'b1);
        issue_request(make_request(CMD_INSERT, 3, 0), 1'b1);
        issue_request(make_request(CMD_SEARCH, 0, 0), 1'b1);
        issue_request(make_request(CMD_SEARCH, 63, 12345), 1'b1);
        issue_request(make_request(CMD_DELETE, 63, 0), 1'b1);
        issue_request(make_request(CMD_DELETE, 5, 0), 1'b1);
        issue_request(make_request(CMD_DELETE, 0, 0), 1'b1);
        issue_request(make_request(CMD_DELETE, 3, 0), 1'b1);
        issue_request(make_request(CMD_SPARE_FIRST, 63, -1), 1'b1);
        issue_request(make_request(CMD_SPARE_MID, 42, WORD_MAX), 1'b1);
        issue_request(make_request(CMD_SPARE_LAST, 21, WORD_MIN), 1'b1);
        issue_request(make_request(CMD_DUMP, 0, 0), 1'b1);
        issue_request(make_request(CMD_SEARCH, 0, WORD_MIN), 1'b1);

        for (int k = 0; k < RANDOM_ITEMS; k++)
            issue_request(random_request(), !(k >= 8 && k < 20));

        // Fill the list to its limit, then exercise the full cases.
        while (board.count < LIST_DEPTH)
            if ($urandom_range(3) == 0)
                issue_request(make_request(CMD_INSERT, $urandom_range(board.count),
                                           pick_word()), 1'b1);
            else
                issue_request(make_request(CMD_APPEND, $urandom, pick_word()), 1'b1);
        issue_request(make_request(CMD_INSERT, $urandom, pick_word()), 1'b1);
        issue_request(make_request(CMD_APPEND, $urandom, pick_word()), 1'b1);
        issue_request(make_request(CMD_DUMP, $urandom, $urandom), 1'b1);
        issue_request(make_request(CMD_SEARCH, 0,
                                   board.elements[$urandom_range(LIST_DEPTH - 1)]), 1'b1);
        issue_request(make_request(CMD_SEARCH, 0, $urandom), 1'b1);

        // One delete from the full list, then a last look at the whole list.
        issue_request(make_request(CMD_DELETE, $urandom_range(LIST_DEPTH - 1), 0), 1'b1);
        issue_request(make_request(CMD_DUMP, 0, 0), 1'b1);
        start <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
